### hw/rtl/srlm_pkg.sv
// ----------------------------------------------------------------------------
// srlm_pkg
// shared widths, codes and sample conversion for the stereo level meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srlm_pkg;

  localparam int RAW_W      = 32;
  localparam int LEVEL_W    = 16;
  localparam int MAG_W      = 16;
  localparam int DIG_W      = 4;
  localparam int DIG_LOG2   = 2;
  localparam int DIGITS     = MAG_W / DIG_W;
  localparam int PP_W       = MAG_W + DIG_W;
  localparam int SQ_LOG2    = 30;
  localparam int Q_W        = SQ_LOG2 + 1;
  localparam int ROOT_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  localparam int FMT_W      = 2;

  localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_S32 = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FORMAT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MONO   = 1'b1;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'h8000;

  typedef struct packed {
    logic load;
    logic clear;
  } srlm_acc_ctl_t;

  // magnitude of the q1.15 value of one raw sample
  function automatic logic [MAG_W-1:0] q15_mag(input logic [FMT_W-1:0] fmt,
                                               input logic [RAW_W-1:0] raw);
    logic [MAG_W-1:0] s;
    case (fmt)
      FMT_U8:  s = {raw[7:0] ^ 8'h80, 8'h00};
      FMT_S16: s = raw[15:0];
      FMT_S32: s = raw[31:16];
      default: s = '0;
    endcase
    return s[MAG_W-1] ? (~s + MAG_W'(1)) : s;
  endfunction

endpackage

### hw/rtl/srlm_if.sv
// ----------------------------------------------------------------------------
// srlm_if
// valid/ready channels of the stereo level meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface srlm_in_if;
  import srlm_pkg::*;
  logic               valid;
  logic               ready;
  logic [RAW_W-1:0]   left_raw;
  logic [RAW_W-1:0]   right_raw;
  logic               frame_end;
  modport source(output valid, left_raw, right_raw, frame_end, input ready);
  modport sink(input valid, left_raw, right_raw, frame_end, output ready);
endinterface

interface srlm_out_if;
  import srlm_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] left_level;
  logic [LEVEL_W-1:0] right_level;
  modport source(output valid, left_level, right_level, input ready);
  modport sink(input valid, left_level, right_level, output ready);
endinterface

interface srlm_cfg_if;
  import srlm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hw/rtl/srlm_sq_acc.sv
// ----------------------------------------------------------------------------
// srlm_sq_acc
// digit-serial square and accumulate, one 4-bit digit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srlm_sq_acc #(
  parameter int SUM_W = 47
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  srlm_pkg::srlm_acc_ctl_t ctl,
  input  logic [15:0]             mag_in,
  output logic                    last,
  output logic [SUM_W-1:0]        sum
);
  import srlm_pkg::*;

  localparam int DC_W = $clog2(DIGITS);
  localparam int SH_W = DC_W + DIG_LOG2;

  logic             busy_r, busy_nxt;
  logic [DC_W-1:0]  dig_r, dig_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [MAG_W-1:0] mul_r, mul_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [PP_W-1:0]  pp;
  logic [SH_W-1:0]  shamt;

  always_comb begin
    pp    = PP_W'(mag_r) * PP_W'(mul_r[DIG_W-1:0]);
    shamt = {dig_r, {DIG_LOG2{1'b0}}};
    last  = busy_r && (dig_r == DC_W'(DIGITS - 1));
    sum_nxt = busy_r ? (sum_r + (SUM_W'(pp) << shamt)) : sum_r;
    if (ctl.clear) begin
      sum_nxt = '0;
    end
    busy_nxt = busy_r;
    dig_nxt  = dig_r;
    mag_nxt  = mag_r;
    mul_nxt  = mul_r;
    if (ctl.load) begin
      busy_nxt = 1'b1;
      dig_nxt  = '0;
      mag_nxt  = mag_in;
      mul_nxt  = mag_in;
    end else if (busy_r) begin
      dig_nxt = dig_r + DC_W'(1);
      mul_nxt = mul_r >> DIG_W;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      dig_r  <= '0;
      sum_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      dig_r  <= dig_nxt;
      sum_r  <= sum_nxt;
    end
    mag_r <= mag_nxt;
    mul_r <= mul_nxt;
  end

  assign sum = sum_r;

endmodule

### hw/rtl/srlm_div.sv
// ----------------------------------------------------------------------------
// srlm_div
// bit-serial restoring divider, sum over pair count, one bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srlm_div #(
  parameter int SUM_W = 47,
  parameter int CNT_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [30:0]      quotient
);
  import srlm_pkg::*;

  localparam int IT_W = $clog2(SUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [IT_W-1:0]  it_r, it_nxt;
  logic [SUM_W-1:0] dvd_r, dvd_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W:0]   rem_sh;
  logic             fits;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[SUM_W-1]};
    fits     = rem_sh >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    it_nxt   = it_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      it_nxt   = IT_W'(SUM_W - 1);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? CNT_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[CNT_W-1:0];
      dvd_nxt = {dvd_r[SUM_W-2:0], fits};
      it_nxt  = it_r - IT_W'(1);
      if (it_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      it_r   <= it_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r[Q_W-1:0];

endmodule

### hw/rtl/srlm_sqrt.sv
// ----------------------------------------------------------------------------
// srlm_sqrt
// digit-by-digit floor square root, one root bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srlm_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [30:0] radicand,
  output logic        done,
  output logic [15:0] root
);
  import srlm_pkg::*;

  localparam int X_W  = 2 * ROOT_W;
  localparam int R_W  = ROOT_W + 2;
  localparam int SH_W = R_W + 2;
  localparam int IT_W = $clog2(ROOT_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [IT_W-1:0]   it_r, it_nxt;
  logic [X_W-1:0]    x_r, x_nxt;
  logic [R_W-1:0]    rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [SH_W-1:0]   rem_sh;
  logic [SH_W-1:0]   trial;
  logic              fits;

  always_comb begin
    rem_sh   = {rem_r, x_r[X_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    fits     = rem_sh >= trial;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    it_nxt   = it_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      it_nxt   = IT_W'(ROOT_W - 1);
      x_nxt    = X_W'(radicand);
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? R_W'(rem_sh - trial) : R_W'(rem_sh);
      root_nxt = {root_r[ROOT_W-2:0], fits};
      x_nxt    = x_r << 2;
      it_nxt   = it_r - IT_W'(1);
      if (it_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      it_r   <= it_nxt;
    end
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### hw/rtl/stereo_rms_level_meter_top.sv
// ----------------------------------------------------------------------------
// stereo_rms_level_meter_top
// Stereo RMS level meter. Each beat on the input channel is one sample pair
// in the configured format (offset u8, s16, or the top half of s32); both
// samples are squared four bits at a time, and a new pair is taken in the
// cycle the previous squaring finishes unless that pair ended a frame. On a
// pair marked frame_end the block divides both sums by the pair count in a
// bit-serial divider and takes the square root one bit per cycle; after the
// last pair's squaring, the division and the root, the levels sit in the
// output register, and only then is input taken again. The pair count stops
// at MAX_FRAME_SAMPLES; later pairs of that frame are ignored.
// Configuration writes are taken at any time after reset, but belong
// between frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_rms_level_meter_top #(
  parameter int MAX_FRAME_SAMPLES = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  srlm_in_if.sink           in_ch,
  srlm_out_if.source        out_ch,
  srlm_cfg_if.sink          cfg_ch
);
  import srlm_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SUM_W = SQ_LOG2 + CNT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_DGO  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]         st_r, st_nxt;
  logic [FMT_W-1:0]   fmt_r;
  logic               mono_r;
  logic               fe_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               out_valid_r;
  logic [LEVEL_W-1:0] left_lvl_r;
  logic [LEVEL_W-1:0] right_lvl_r;

  srlm_acc_ctl_t      acc_ctl;
  logic [MAG_W-1:0]   mag_lt, mag_rt;
  logic               last_lt, last_rt, sq_last;
  logic [SUM_W-1:0]   sum_lt, sum_rt;
  logic               div_start, div_done_lt, div_done_rt, div_done;
  logic [Q_W-1:0]     quo_lt, quo_rt;
  logic               root_start, root_done_lt, root_done_rt, root_done;
  logic [ROOT_W-1:0]  root_lt, root_rt;
  logic               sat, in_rdy, in_acc, out_load, cfg_acc;

  srlm_sq_acc #(.SUM_W(SUM_W)) u_sq_l (
    .clk(clk), .rst_n(rst_n), .ctl(acc_ctl), .mag_in(mag_lt),
    .last(last_lt), .sum(sum_lt)
  );
  srlm_sq_acc #(.SUM_W(SUM_W)) u_sq_r (
    .clk(clk), .rst_n(rst_n), .ctl(acc_ctl), .mag_in(mag_rt),
    .last(last_rt), .sum(sum_rt)
  );
  srlm_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_l (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_lt),
    .divisor(cnt_r), .done(div_done_lt), .quotient(quo_lt)
  );
  srlm_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_r (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_rt),
    .divisor(cnt_r), .done(div_done_rt), .quotient(quo_rt)
  );
  srlm_sqrt u_sqrt_l (
    .clk(clk), .rst_n(rst_n), .start(root_start), .radicand(quo_lt),
    .done(root_done_lt), .root(root_lt)
  );
  srlm_sqrt u_sqrt_r (
    .clk(clk), .rst_n(rst_n), .start(root_start), .radicand(quo_rt),
    .done(root_done_rt), .root(root_rt)
  );

  always_comb begin
    sat    = cnt_r == CNT_W'(MAX_FRAME_SAMPLES);
    mag_lt = sat ? '0 : q15_mag(fmt_r, in_ch.left_raw);
    mag_rt = sat ? '0 : (mono_r ? q15_mag(fmt_r, in_ch.left_raw)
                                : q15_mag(fmt_r, in_ch.right_raw));
    sq_last   = last_lt & last_rt;
    div_done  = div_done_lt & div_done_rt;
    root_done = root_done_lt & root_done_rt;
    case (st_r)
      ST_IDLE: in_rdy = 1'b1;
      ST_SQ:   in_rdy = sq_last && !fe_r;
      default: in_rdy = 1'b0;
    endcase
    in_acc        = in_ch.valid && in_ch.ready;
    out_load      = (st_r == ST_OUT) && (!out_valid_r || out_ch.ready);
    acc_ctl.load  = in_acc;
    acc_ctl.clear = out_load;
    div_start     = st_r == ST_DGO;
    root_start    = (st_r == ST_DIV) && div_done;
    cfg_acc       = cfg_ch.valid && cfg_ch.ready;

    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) st_nxt = ST_SQ;
      end
      ST_SQ: begin
        if (sq_last) begin
          if (fe_r) st_nxt = ST_DGO;
          else if (!in_acc) st_nxt = ST_IDLE;
        end
      end
      ST_DGO:  st_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) st_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_done) st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready  = rst_n && in_rdy;
  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      fmt_r       <= FMT_S16;
      mono_r      <= 1'b0;
      fe_r        <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_acc) begin
        case (cfg_ch.index)
          CFG_IDX_FORMAT: fmt_r  <= cfg_ch.data[FMT_W-1:0];
          CFG_IDX_MONO:   mono_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        fe_r <= in_ch.frame_end;
      end
      if (out_load) begin
        cnt_r <= '0;
      end else if (in_acc && !sat) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (out_load) begin
      left_lvl_r  <= (root_lt > LEVEL_ONE) ? LEVEL_ONE : root_lt;
      right_lvl_r <= (root_rt > LEVEL_ONE) ? LEVEL_ONE : root_rt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_level  = left_lvl_r;
  assign out_ch.right_level = right_lvl_r;

endmodule

### hw/rtl/srlm_checker.sv
// ----------------------------------------------------------------------------
// srlm_checker
// port-level checks of the stereo level meter, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srlm_checker (
  input logic        clk,
  input logic        rst_n,
  srlm_in_if.sink    in_ch,
  srlm_out_if.source out_ch
);
  import srlm_pkg::*;

  // a result beat waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result beat dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=>
      $stable(out_ch.left_level) && $stable(out_ch.right_level))
    else $error("result beat changed while stalled");

  // squaring keeps the input closed for the cycle after a beat
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken again right after a beat");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.left_level <= LEVEL_ONE) &&
                     (out_ch.right_level <= LEVEL_ONE))
    else $error("level above full scale");

endmodule

bind stereo_rms_level_meter_top srlm_checker u_srlm_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ch(in_ch),
  .out_ch(out_ch)
);
